// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/o3d_pkg.sv -----
// Shared types and constants of the orientation predicate.
package o3d_pkg;

   typedef logic [1:0] orient_type;

   localparam orient_type ORIENT_ZERO = 2'b00;
   localparam orient_type ORIENT_POS  = 2'b01;
   localparam orient_type ORIENT_NEG  = 2'b11;

   localparam int NUM_STAGES = 8;
   localparam int RSP_DATA_W = 8;
   localparam int ORIENT_W   = 2;

endpackage

// ----- rtl/core/orient3d_exact_sign.sv -----
// Top level: exact sign of the 3-D orientation determinant of four points.
//
//   Channel  Direction  tdata fields (lowest bits first)
//   req      in         a_x a_y a_z b_x b_y b_z c_x c_y c_z d_x d_y d_z
//   rsp      out        orientation (2 bits, zero padded to a byte)
//
// The pipeline has eight register stages and accepts one word per cycle
// while the result side does not stall. The depth is set by the two
// chained multiplications, the second of which is split into two partial
// products, and by the wide additions that follow. Synchronous reset
// clears only the valid bits. A stall on rsp holds the last stage; earlier
// stages keep filling empty slots, so req stays ready while bubbles remain.
module orient3d_exact_sign
   import o3d_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // orientation in bits 1:0, zeros above
   output logic [RSP_DATA_W-1:0]               rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;          // coordinate difference
   localparam int PW    = 2 * W + 2;      // product of two differences
   localparam int MW    = 2 * W + 3;      // 2x2 minor
   localparam int LO    = W + 2;          // low slice of a minor, unsigned
   localparam int HW    = MW - LO;        // high slice of a minor, signed
   localparam int LOPW  = DW + LO + 1;    // difference times low slice
   localparam int HIPW  = DW + HW;        // difference times high slice
   localparam int DETW  = 3 * W + 6;      // determinant and its partial sums

   logic [NUM_STAGES-1:0] load;

   o3d_pipe_ctrl #(
      .STAGES(NUM_STAGES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .load     (load)
   );

   // Stage 1: the nine differences against point d.
   // Index order: adx ady adz bdx bdy bdz cdx cdy cdz.
   logic signed [W-1:0]  coord [12];
   logic signed [DW-1:0] diff_in [9];
   logic signed [DW-1:0] diff_ff [9];

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         coord[i] = req_tdata[i*W +: W];
      end
      for (int i = 0; i < 9; i++) begin
         diff_in[i] = $signed({coord[i][W-1], coord[i]})
                    - $signed({coord[9 + (i % 3)][W-1], coord[9 + (i % 3)]});
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         diff_ff <= diff_in;
      end
   end

   // Stage 2: the six products of the minors; the x differences ride along.
   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];
   logic signed [DW-1:0] x1_ff [3];

   always_comb begin
      prod_in[0] = diff_ff[4] * diff_ff[8];   // bdy * cdz
      prod_in[1] = diff_ff[5] * diff_ff[7];   // bdz * cdy
      prod_in[2] = diff_ff[7] * diff_ff[2];   // cdy * adz
      prod_in[3] = diff_ff[8] * diff_ff[1];   // cdz * ady
      prod_in[4] = diff_ff[1] * diff_ff[5];   // ady * bdz
      prod_in[5] = diff_ff[2] * diff_ff[4];   // adz * bdy
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         prod_ff <= prod_in;
         x1_ff[0] <= diff_ff[0];
         x1_ff[1] <= diff_ff[3];
         x1_ff[2] <= diff_ff[6];
      end
   end

   // Stage 3: the three minors.
   logic signed [MW-1:0] minor_in [3];
   logic signed [MW-1:0] minor_ff [3];
   logic signed [DW-1:0] x2_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         minor_in[j] = $signed({prod_ff[2*j][PW-1], prod_ff[2*j]})
                     - $signed({prod_ff[2*j+1][PW-1], prod_ff[2*j+1]});
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         minor_ff <= minor_in;
         x2_ff    <= x1_ff;
      end
   end

   // Stage 4: each x difference times the minor, split into an unsigned
   // low slice and a signed high slice so that each multiplier stays narrow.
   logic signed [LOPW-1:0] lo_in [3];
   logic signed [LOPW-1:0] lo_ff [3];
   logic signed [HIPW-1:0] hi_in [3];
   logic signed [HIPW-1:0] hi_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = x2_ff[j] * $signed({1'b0, minor_ff[j][LO-1:0]});
         hi_in[j] = x2_ff[j] * $signed(minor_ff[j][MW-1:LO]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // Stage 5: recombine the slices into the three full terms.
   logic signed [DETW-1:0] term_in [3];
   logic signed [DETW-1:0] term_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = ($signed({{(DETW-HIPW){hi_ff[j][HIPW-1]}}, hi_ff[j]}) <<< LO)
                    + $signed({{(DETW-LOPW){lo_ff[j][LOPW-1]}}, lo_ff[j]});
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         term_ff <= term_in;
      end
   end

   // Stage 6: first partial sum.
   logic signed [DETW-1:0] sum_ff;
   logic signed [DETW-1:0] term2_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         sum_ff   <= term_ff[0] + term_ff[1];
         term2_ff <= term_ff[2];
      end
   end

   // Stage 7: the determinant.
   logic signed [DETW-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         det_ff <= sum_ff + term2_ff;
      end
   end

   // Stage 8: sign of the determinant into the output register.
   orient_type orient_in;
   orient_type orient_ff;

   always_comb begin
      if (det_ff[DETW-1]) begin
         orient_in = ORIENT_NEG;
      end else if (det_ff == '0) begin
         orient_in = ORIENT_ZERO;
      end else begin
         orient_in = ORIENT_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (load[7]) begin
         orient_ff <= orient_in;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-ORIENT_W){1'b0}}, orient_ff};

endmodule

// ----- rtl/core/o3d_pipe_ctrl.sv -----
// Valid and load control for a stallable pipeline that collapses bubbles.
module o3d_pipe_ctrl #(
   parameter int STAGES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] load
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   rdy;

   // A stage can take a word when it is empty or its content moves on.
   always_comb begin
      rdy[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      load = rdy[STAGES-1:0];
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

// ----- rtl/core/o3d_checker.sv -----
// Port-level checks of the orientation predicate and their binding.
`include "assert_macros.svh"

module o3d_checker
   import o3d_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(NUM_STAGES + 1);

   logic          req_acc;
   logic          rsp_acc;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Words accepted and not yet delivered.
   always_comb begin
      count_in = count_ff;
      if (req_acc && !rsp_acc) begin
         count_in = count_ff + CW'(1);
      end else if (!req_acc && rsp_acc) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `ASSERT_SAME(a_orient_code, clock, reset, rsp_tvalid,
      (rsp_tdata[ORIENT_W-1:0] == ORIENT_NEG) || (rsp_tdata[ORIENT_W-1:0] == ORIENT_ZERO)
      || (rsp_tdata[ORIENT_W-1:0] == ORIENT_POS))
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_SAME(a_no_phantom, clock, reset, rsp_tvalid, count_ff != '0)
   `ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, count_ff <= CW'(NUM_STAGES))
   `ASSERT_SAME(a_empty_ready, clock, reset, count_ff == '0, req_tready)

endmodule

bind orient3d_exact_sign o3d_checker u_o3d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// ----- test/tb.sv -----
// Self-checking testbench for orient3d_exact_sign: directed table, random words, flow control.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import o3d_pkg::*;

   // The block runs at its default coordinate width. One req word carries twelve
   // coordinates; the rsp word carries the two-bit orientation, zero padded.
   localparam int COORD_W     = 32;
   localparam int REQ_W       = ((12*COORD_W+7)/8)*8;
   localparam int LATENCY     = NUM_STAGES;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 170;
   localparam int PRESS_WORDS = 70;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   // The members are listed from the highest bits down. Because of that a whole
   // tetra_type has exactly the req_tdata layout, with a_x in the lowest bits.
   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_type;
   typedef struct packed {
      point_type d;
      point_type c;
      point_type b;
      point_type a;
   } tetra_type;

   // The determinant of 33-bit differences needs about 102 bits, so 128 bits
   // of signed arithmetic hold every product and sum exactly.
   typedef logic signed [127:0] det_type;

   // One row of the directed table. Where known is set, the orientation is
   // typed in by hand; other rows are checked against the predictor.
   typedef struct {
      tetra_type  pts;
      bit         known;
      orient_type want;
   } vector_type;

   localparam coord_type C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   // Expected orientation of the word on req_tdata. It is driven together with
   // the word, so the monitor can pick it up at the accepting edge.
   orient_type want_shadow = ORIENT_ZERO;
   orient_type expected_orient [$];
   vector_type directed_rows [$];

   int idle_pct = 0;        // chance in percent that the sender idles a cycle
   int stall_pct = 0;       // chance in percent that the receiver stalls a cycle
   logic hold_rsp = 1'b0;   // long receiver hold-off during the pressure phase
   int mismatch_count = 0;
   int cycle_count = 0;

   orient3d_exact_sign #(
      .COORD_WIDTH(COORD_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact sign of (a-d) . ((b-d) x (c-d)), worked out in wide signed integers.
   function automatic orient_type orientation_of(tetra_type t);
      det_type adx, ady, adz, bdx, bdy, bdz, cdx, cdy, cdz, det;
      adx = det_type'(t.a.x) - det_type'(t.d.x);
      ady = det_type'(t.a.y) - det_type'(t.d.y);
      adz = det_type'(t.a.z) - det_type'(t.d.z);
      bdx = det_type'(t.b.x) - det_type'(t.d.x);
      bdy = det_type'(t.b.y) - det_type'(t.d.y);
      bdz = det_type'(t.b.z) - det_type'(t.d.z);
      cdx = det_type'(t.c.x) - det_type'(t.d.x);
      cdy = det_type'(t.c.y) - det_type'(t.d.y);
      cdz = det_type'(t.c.z) - det_type'(t.d.z);
      det = adx * (bdy * cdz - bdz * cdy)
          + bdx * (cdy * adz - cdz * ady)
          + cdx * (ady * bdz - adz * bdy);
      if (det < 0) begin
         return ORIENT_NEG;
      end else if (det == 0) begin
         return ORIENT_ZERO;
      end
      return ORIENT_POS;
   endfunction

   function automatic tetra_type tet(coord_type ax, coord_type ay, coord_type az,
                                     coord_type bx, coord_type by, coord_type bz,
                                     coord_type cx, coord_type cy, coord_type cz,
                                     coord_type dx, coord_type dy, coord_type dz);
      tetra_type t;
      t.a = '{z: az, y: ay, x: ax};
      t.b = '{z: bz, y: by, x: bx};
      t.c = '{z: cz, y: cy, x: cx};
      t.d = '{z: dz, y: dy, x: dx};
      return t;
   endfunction

   // Appends one row to the directed table.
   task automatic add_row(input tetra_type pts, input bit known, input orient_type want);
      vector_type row;
      row.pts   = pts;
      row.known = known;
      row.want  = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Random tetrahedra of several shapes. Plain full-range words almost never
   // land on a zero determinant, so a good share is built coplanar on purpose,
   // some of it nudged by one unit to get tiny nonzero determinants.
   function automatic tetra_type random_tetra();
      logic [11:0][COORD_W-1:0] raw;
      tetra_type t;
      point_type u, v;
      point_type p [3];
      int pick, s, r;
      pick = $urandom_range(99);
      for (int i = 0; i < 12; i++) begin
         raw[i] = $urandom;
      end
      t = raw;
      if (pick < 45) begin
         return t;
      end
      if (pick < 60) begin
         // Tiny coordinates: coincident and degenerate points are common here.
         for (int i = 0; i < 12; i++) begin
            raw[i] = coord_type'(int'($urandom_range(8)) - 4);
         end
         return raw;
      end
      if (pick < 80) begin
         // Points a, b and c are d plus integer combinations of two vectors.
         t.d.x = coord_type'(int'($urandom_range(1 << 30)) - (1 << 29));
         t.d.y = coord_type'(int'($urandom_range(1 << 30)) - (1 << 29));
         t.d.z = coord_type'(int'($urandom_range(1 << 30)) - (1 << 29));
         u.x = coord_type'(int'($urandom_range(2048)) - 1024);
         u.y = coord_type'(int'($urandom_range(2048)) - 1024);
         u.z = coord_type'(int'($urandom_range(2048)) - 1024);
         v.x = coord_type'(int'($urandom_range(2048)) - 1024);
         v.y = coord_type'(int'($urandom_range(2048)) - 1024);
         v.z = coord_type'(int'($urandom_range(2048)) - 1024);
         for (int k = 0; k < 3; k++) begin
            s = int'($urandom_range(512)) - 256;
            r = int'($urandom_range(512)) - 256;
            p[k].x = coord_type'(int'(t.d.x) + s * int'(u.x) + r * int'(v.x));
            p[k].y = coord_type'(int'(t.d.y) + s * int'(u.y) + r * int'(v.y));
            p[k].z = coord_type'(int'(t.d.z) + s * int'(u.z) + r * int'(v.z));
         end
         if ($urandom_range(1) == 1) begin
            s = $urandom_range(2);
            p[s].z = ($urandom_range(1) == 1) ? p[s].z + 1 : p[s].z - 1;
         end
         t.a = p[0];
         t.b = p[1];
         t.c = p[2];
         return t;
      end
      if (pick < 90) begin
         // Full-range points that share one coordinate: an axis-aligned plane.
         raw[0] = $urandom;
         case ($urandom_range(2))
            0: begin
               t.a.x = raw[0]; t.b.x = raw[0]; t.c.x = raw[0]; t.d.x = raw[0];
            end
            1: begin
               t.a.y = raw[0]; t.b.y = raw[0]; t.c.y = raw[0]; t.d.y = raw[0];
            end
            default: begin
               t.a.z = raw[0]; t.b.z = raw[0]; t.c.z = raw[0]; t.d.z = raw[0];
            end
         endcase
         return t;
      end
      // Every coordinate drawn from the corners of the range and around zero.
      for (int i = 0; i < 12; i++) begin
         case ($urandom_range(6))
            0:       raw[i] = C_MIN;
            1:       raw[i] = C_MAX;
            2:       raw[i] = '0;
            3:       raw[i] = coord_type'(1);
            4:       raw[i] = coord_type'(-1);
            5:       raw[i] = C_MIN + 1;
            default: raw[i] = C_MAX - 1;
         endcase
      end
      return raw;
   endfunction

   task automatic flag_mismatch(input string what, input orient_type want,
                                input logic [RSP_DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected orientation %b, got rsp word %h",
                  $realtime, what, want, got);
      end
   endtask

   // Offers one word and returns right after the edge that accepted it. While
   // the sender idles, valid is low and the data lines carry junk.
   task automatic push_word(input tetra_type t, input orient_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'(random_tetra());
         @(posedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= REQ_W'(t);
      want_shadow <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // The sender pauses until every expected word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_orient.size() != 0);
   endtask

   // Receiver side. The random stall chance changes per phase; the hold-off
   // flag overrides it during the pressure phase.
   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
   end

   // Monitor and scoreboard. Every accepted req word queues its expected
   // orientation; every accepted rsp word is compared against the oldest one.
   // The padding bits above the orientation must stay zero, so the whole rsp
   // word is compared against the zero-extended orientation.
   always @(posedge clock) begin : scoreboard
      orient_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_orient.insert(expected_orient.size(), want_shadow);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_orient.size() == 0) begin
               flag_mismatch("rsp word with nothing expected", ORIENT_ZERO, rsp_tdata);
            end else begin
               want = expected_orient.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(want)) begin
                  flag_mismatch("orientation mismatch", want, rsp_tdata);
               end
            end
         end
      end
   end

   // Watchdog: a run that reaches CYCLE_LIMIT fails.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      tetra_type t;
      int idle_by_phase [4];
      int stall_by_phase [4];

      // Four flow-control phases: free running, a sparse sender, a receiver
      // that mostly stalls, and light random gaps on both sides.
      idle_by_phase  = '{0, 85, 0, 12};
      stall_by_phase = '{0, 0, 85, 12};

      // Directed table. The typed-in orientations are the ones that can be seen
      // at once: degenerate points, unit and diagonal tetrahedra, and row swaps.
      add_row(tet(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ORIENT_ZERO);
      add_row(tet(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0), 1'b1, ORIENT_POS);
      add_row(tet(0, 1, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0), 1'b1, ORIENT_NEG);
      add_row(tet(-1, 0, 0, 0, -1, 0, 0, 0, -1, 0, 0, 0), 1'b1, ORIENT_NEG);
      add_row(tet(101, 100, 100, 100, 101, 100, 100, 100, 101, 100, 100, 100),
              1'b1, ORIENT_POS);
      // Two coincident points, then three collinear ones.
      add_row(tet(5, -7, 9, 5, -7, 9, 1, 2, 3, 0, 0, 0), 1'b1, ORIENT_ZERO);
      add_row(tet(1, 1, 1, 2, 2, 2, 3, 3, 3, 0, 0, 0), 1'b1, ORIENT_ZERO);
      // Largest possible differences on the diagonal, in both orders.
      add_row(tet(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                  C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN),
              1'b1, ORIENT_POS);
      add_row(tet(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                  C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN),
              1'b1, ORIENT_NEG);
      add_row(tet(C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                  C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX),
              1'b1, ORIENT_NEG);
      // All four points on one corner of the range.
      add_row(tet(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                  C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX),
              1'b1, ORIENT_ZERO);
      add_row(tet(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                  C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN),
              1'b1, ORIENT_ZERO);
      // Planes at the edge of the range with far-apart points.
      add_row(tet(C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                  12345, -999, C_MAX, 0, 0, C_MAX),
              1'b1, ORIENT_ZERO);
      add_row(tet(C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX,
                  C_MIN, 7, -7, C_MIN, C_MAX, C_MAX),
              1'b1, ORIENT_ZERO);
      // One unit off the edge plane: the determinant is tiny against the sizes.
      add_row(tet(C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                  12345, -999, C_MAX - 1, 0, 0, C_MAX),
              1'b0, ORIENT_ZERO);
      add_row(tet(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                  C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX),
              1'b0, ORIENT_ZERO);
      add_row(tet(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555),
              1'b0, ORIENT_ZERO);
      add_row(tet(32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_FFFF,
                  32'hFFFF_0000, 32'h0000_FFFF, 32'h7FFF_0000,
                  32'h8000_FFFF, 32'hFFFF_0000, 32'h0000_FFFF,
                  32'hFFFF_0000, 32'hFFFF_0001, 32'h0000_FFFE),
              1'b0, ORIENT_ZERO);

      // Reset is held at the start and released once.
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         push_word(directed_rows[i].pts,
                   directed_rows[i].known ? directed_rows[i].want
                                          : orientation_of(directed_rows[i].pts));
      end
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_by_phase[ph];
         stall_pct <= stall_by_phase[ph];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            t = random_tetra();
            push_word(t, orientation_of(t));
         end
         wait_drained();
      end

      // Pressure: the receiver holds off for a long stretch in its own process
      // while the sender keeps offering back to back. The pipeline fills, and
      // req_tready has to drop until the hold-off ends.
      idle_pct = 0;
      stall_pct <= 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         for (int n = 0; n < PRESS_WORDS; n++) begin
            t = random_tetra();
            push_word(t, orientation_of(t));
         end
      join
      wait_drained();

      // Let any stray rsp word show up before the verdict.
      repeat (2*LATENCY) @(posedge clock);
      if (mismatch_count == 0 && expected_orient.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
